// ===== sv/ldr_pkg.sv =====
package ldr_pkg;

	// Result kinds as seen on the kind port
	typedef enum logic [1:0] {
		KIND_READ        = 2'd0,
		KIND_DONE        = 2'd1,
		KIND_UNSUPPORTED = 2'd2,
		KIND_SEQUENCE    = 2'd3
	} kind_t;

	// Opcodes handled by the unit
	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
	localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
	localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
	localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
	localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
	localparam logic [7:0] OP_LDX_ZPY = 8'hB6;
	localparam logic [7:0] OP_LDA_ABS = 8'hAD;
	localparam logic [7:0] OP_LDX_ABS = 8'hAE;
	localparam logic [7:0] OP_LDY_ABS = 8'hAC;
	localparam logic [7:0] OP_LDA_ABX = 8'hBD;
	localparam logic [7:0] OP_LDY_ABX = 8'hBC;
	localparam logic [7:0] OP_LDA_ABY = 8'hB9;
	localparam logic [7:0] OP_LDX_ABY = 8'hBE;
	localparam logic [7:0] OP_LDA_INX = 8'hA1;
	localparam logic [7:0] OP_LDA_INY = 8'hB1;

	localparam logic [15:0] LEN_SHORT = 16'd2;
	localparam logic [15:0] LEN_LONG  = 16'd3;

	typedef enum logic [3:0] {
		MODE_NONE,
		MODE_IMM,
		MODE_ZP,
		MODE_ZPX,
		MODE_ZPY,
		MODE_ABS,
		MODE_ABX,
		MODE_ABY,
		MODE_INX,
		MODE_INY
	} mode_t;

	typedef enum logic [1:0] {
		DEST_A,
		DEST_X,
		DEST_Y
	} dest_t;

	// One result transaction
	typedef struct packed {
		kind_t       kind;
		logic [15:0] read_address;
		logic [7:0]  accumulator;
		logic [7:0]  x_index;
		logic [7:0]  y_index;
		logic [15:0] program_counter;
		logic        negative_flag;
		logic        zero_flag;
	} result_t;

	function automatic mode_t mode_of(input logic [7:0] op);
		mode_t m;
		case (op)
			OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM: m = MODE_IMM;
			OP_LDA_ZP, OP_LDX_ZP, OP_LDY_ZP:    m = MODE_ZP;
			OP_LDA_ZPX, OP_LDY_ZPX:             m = MODE_ZPX;
			OP_LDX_ZPY:                         m = MODE_ZPY;
			OP_LDA_ABS, OP_LDX_ABS, OP_LDY_ABS: m = MODE_ABS;
			OP_LDA_ABX, OP_LDY_ABX:             m = MODE_ABX;
			OP_LDA_ABY, OP_LDX_ABY:             m = MODE_ABY;
			OP_LDA_INX:                         m = MODE_INX;
			OP_LDA_INY:                         m = MODE_INY;
			default:                            m = MODE_NONE;
		endcase
		return m;
	endfunction

	function automatic dest_t dest_of(input logic [7:0] op);
		dest_t d;
		case (op)
			OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABY: d = DEST_X;
			OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABX: d = DEST_Y;
			default:                                                   d = DEST_A;
		endcase
		return d;
	endfunction

	function automatic logic [15:0] length_of(input mode_t m);
		return (m == MODE_ABS || m == MODE_ABX || m == MODE_ABY) ? LEN_LONG : LEN_SHORT;
	endfunction

endpackage

// ===== sv/ldr_core.sv =====
module ldr_core import ldr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        func,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand_low,
	input  logic [7:0]  operand_high,
	input  logic [7:0]  read_data,
	output result_t     result
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_OPERAND,
		PH_PTR_LO,
		PH_PTR_HI
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  a_q, a_n;
	logic [7:0]  x_q, x_n;
	logic [7:0]  y_q, y_n;
	logic [15:0] pc_q, pc_n;
	logic        n_q, n_n;
	logic        z_q, z_n;
	logic [7:0]  opc_q, opc_n;
	logic [7:0]  ptr_q, ptr_n;
	logic [7:0]  low_q, low_n;

	kind_t       kind;
	logic [15:0] addr;
	mode_t       mode;
	logic        load;
	logic [7:0]  load_op;
	logic [7:0]  load_val;
	logic [7:0]  ptr_sel;
	logic [15:0] iy_add;

	// Next state and result for the transaction at the port
	always_comb begin
		phase_n  = phase_q;
		opc_n    = opc_q;
		ptr_n    = ptr_q;
		low_n    = low_q;
		kind     = KIND_READ;
		addr     = '0;
		load     = 1'b0;
		load_op  = opc_q;
		load_val = read_data;
		mode     = mode_of(opcode);
		ptr_sel  = (mode == MODE_INX) ? operand_low + x_q : operand_low;
		iy_add   = (mode_of(opc_q) == MODE_INY) ? {8'h00, y_q} : 16'h0000;
		if (!func) begin
			if (phase_q != PH_IDLE) begin
				kind = KIND_SEQUENCE;
			end else if (mode == MODE_NONE) begin
				kind = KIND_UNSUPPORTED;
			end else begin
				opc_n   = opcode;
				phase_n = PH_OPERAND;
				case (mode)
					MODE_IMM: begin
						kind     = KIND_DONE;
						load     = 1'b1;
						load_op  = opcode;
						load_val = operand_low;
						phase_n  = PH_IDLE;
					end
					MODE_ZP:  addr = {8'h00, operand_low};
					MODE_ZPX: addr = {8'h00, operand_low + x_q};
					MODE_ZPY: addr = {8'h00, operand_low + y_q};
					MODE_ABS: addr = {operand_high, operand_low};
					MODE_ABX: addr = {operand_high, operand_low} + {8'h00, x_q};
					MODE_ABY: addr = {operand_high, operand_low} + {8'h00, y_q};
					default: begin
						ptr_n   = ptr_sel;
						phase_n = PH_PTR_LO;
						addr    = {8'h00, ptr_sel};
					end
				endcase
			end
		end else begin
			case (phase_q)
				PH_PTR_LO: begin
					low_n   = read_data;
					phase_n = PH_PTR_HI;
					addr    = {8'h00, ptr_q + 8'd1};
				end
				PH_PTR_HI: begin
					phase_n = PH_OPERAND;
					addr    = {read_data, low_q} + iy_add;
				end
				PH_OPERAND: begin
					kind    = KIND_DONE;
					load    = 1'b1;
					phase_n = PH_IDLE;
				end
				default: kind = KIND_SEQUENCE;
			endcase
		end
	end

	// Register writeback on completion
	always_comb begin
		a_n  = a_q;
		x_n  = x_q;
		y_n  = y_q;
		pc_n = pc_q;
		n_n  = n_q;
		z_n  = z_q;
		if (load) begin
			case (dest_of(load_op))
				DEST_X:  x_n = load_val;
				DEST_Y:  y_n = load_val;
				default: a_n = load_val;
			endcase
			n_n  = load_val[7];
			z_n  = (load_val == 8'h00);
			pc_n = pc_q + length_of(mode_of(load_op));
		end
	end

	assign result.kind            = kind;
	assign result.read_address    = addr;
	assign result.accumulator     = a_n;
	assign result.x_index         = x_n;
	assign result.y_index         = y_n;
	assign result.program_counter = pc_n;
	assign result.negative_flag   = n_n;
	assign result.zero_flag       = z_n;

	// Architectural and sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			a_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			pc_q    <= '0;
			n_q     <= 1'b0;
			z_q     <= 1'b0;
			opc_q   <= '0;
			ptr_q   <= '0;
			low_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			a_q     <= a_n;
			x_q     <= x_n;
			y_q     <= y_n;
			pc_q    <= pc_n;
			n_q     <= n_n;
			z_q     <= z_n;
			opc_q   <= opc_n;
			ptr_q   <= ptr_n;
			low_q   <= low_n;
		end
	end

endmodule

// ===== sv/load_register_instruction_unit.sv =====
// Load unit for 6502 LDA, LDX and LDY in all addressing modes.
// Input channel (item_valid / item_stall): func = 0 carries a new instruction
// (opcode, operand_low, operand_high); func = 1 carries the byte that memory
// returned for the last read request (read_data).
// Result channel (result_valid / result_stall): exactly one result per input
// transaction. kind 0 asks for a read at read_address, kind 1 reports a
// finished load, kind 2 an unsupported opcode, kind 3 an item out of
// sequence. A, X, Y, PC, N and Z are always the values after the step.
// The result is registered; while the result register is stalled, a transaction waits in the skid buffer first.
// Throughput: one transaction per cycle while item_stall is low; decode, the 16-bit adds and the
// register update are combinational between state and result register.
// A one-entry skid buffer sits behind the result register: a transaction
// accepted while the receiver stalls a full result register lands there, and
// item_stall is high for as long as that entry is occupied;
// a stalled result holds its payload.
// Reset (arst_n low) clears A, X, Y, PC, flags and sequencing, and empties
// the result and skid registers.
module load_register_instruction_unit import ldr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand_low,
	input  logic [7:0]  operand_high,
	input  logic [7:0]  read_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [15:0] read_address,
	output logic [7:0]  accumulator,
	output logic [7:0]  x_index,
	output logic [7:0]  y_index,
	output logic [15:0] program_counter,
	output logic        negative_flag,
	output logic        zero_flag
);

	logic    accept;
	logic    out_free;
	result_t res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	assign item_stall = skid_valid_q;
	assign accept     = item_valid && !skid_valid_q;
	assign out_free   = !out_valid_q || !result_stall;

	ldr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (func),
		.opcode       (opcode),
		.operand_low  (operand_low),
		.operand_high (operand_high),
		.read_data    (read_data),
		.result       (res)
	);

	// Valid bits of result register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: skid drains first, otherwise new result goes straight out
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign result_valid    = out_valid_q;
	assign kind            = out_q.kind;
	assign read_address    = out_q.read_address;
	assign accumulator     = out_q.accumulator;
	assign x_index         = out_q.x_index;
	assign y_index         = out_q.y_index;
	assign program_counter = out_q.program_counter;
	assign negative_flag   = out_q.negative_flag;
	assign zero_flag       = out_q.zero_flag;

endmodule

// ===== sv/ldr_checker.sv =====
module ldr_checker import ldr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] read_address,
	input  logic [7:0]  accumulator,
	input  logic [7:0]  x_index,
	input  logic [7:0]  y_index,
	input  logic        negative_flag,
	input  logic        zero_flag
);

	// A stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its kind, address and A, X and Y values
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(kind) && $stable(read_address)
			&& $stable(accumulator) && $stable(x_index) && $stable(y_index))
		else $error("stalled result changed");

	// Only read requests carry an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != KIND_READ |-> read_address == 16'h0000)
		else $error("address on a non-read result");

	// Z reflects a value still held in one of the registers
	a_zero_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_flag |->
			accumulator == 8'h00 || x_index == 8'h00 || y_index == 8'h00)
		else $error("zero flag without a zero register");

	// N reflects a value still held in one of the registers
	a_neg_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && negative_flag |->
			accumulator[7] || x_index[7] || y_index[7])
		else $error("negative flag without a negative register");

endmodule

bind load_register_instruction_unit ldr_checker u_ldr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.kind          (kind),
	.read_address  (read_address),
	.accumulator   (accumulator),
	.x_index       (x_index),
	.y_index       (y_index),
	.negative_flag (negative_flag),
	.zero_flag     (zero_flag)
);
